### rtl/wkbw_pkg.sv
// ----------------------------------------------------------------------------
// wkbw_pkg
// Shared types, register indexes and widths for the kernel bundle point warp.
// ----------------------------------------------------------------------------
package wkbw_pkg;

   // request opcodes
   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_EVAL = 1'b1;

   // configuration register indexes
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 64;
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_LEVELS = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_COMPS  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DESC_0     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DESC_1     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_DESC_2     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_DESC_3     = 3'd5;
   localparam int NDESC = 4;

   // arithmetic widths
   localparam int MUL_W  = 33;
   localparam int PROD_W = 66;
   localparam int SQ_W   = 43;
   localparam int ROOT_W = 22;
   localparam int DIV_W  = 48;
   localparam int DEN_W  = 5;

   typedef logic signed [31:0] q16_type;

   // level descriptor, packed as written through the register port
   typedef struct packed {
      logic [11:0] inv_z;
      logic [11:0] inv_y;
      logic [11:0] inv_x;
      logic [7:0]  gz;
      logic [7:0]  gy;
      logic [7:0]  gx;
      logic [3:0]  sup;
   } desc_type;

   function automatic logic [7:0] desc_g(input desc_type d, input logic [1:0] ax);
      logic [7:0] g;
      case (ax)
         2'd0:    g = d.gx;
         2'd1:    g = d.gy;
         default: g = d.gz;
      endcase
      return g;
   endfunction

   function automatic logic [11:0] desc_inv(input desc_type d, input logic [1:0] ax);
      logic [11:0] v;
      case (ax)
         2'd0:    v = d.inv_x;
         2'd1:    v = d.inv_y;
         default: v = d.inv_z;
      endcase
      return v;
   endfunction

endpackage

### rtl/wkbw_if.sv
// ----------------------------------------------------------------------------
// wkbw request / response channels
// Valid/ready channels carrying the warp requests and the warped points.
// ----------------------------------------------------------------------------
interface wkbw_req_if;
   logic              valid;
   logic              ready;
   logic              op;
   logic [1:0]        level;
   logic [11:0]       coef_index;
   logic signed [31:0] coef_x;
   logic signed [31:0] coef_y;
   logic signed [31:0] coef_z;
   logic signed [31:0] point_x;
   logic signed [31:0] point_y;
   logic signed [31:0] point_z;

   modport source (output valid, op, level, coef_index, coef_x, coef_y, coef_z,
                   point_x, point_y, point_z, input ready);
   modport sink   (input valid, op, level, coef_index, coef_x, coef_y, coef_z,
                   point_x, point_y, point_z, output ready);
endinterface

interface wkbw_rsp_if;
   logic              valid;
   logic              ready;
   logic signed [31:0] out_x;
   logic signed [31:0] out_y;
   logic signed [31:0] out_z;

   modport source (output valid, out_x, out_y, out_z, input ready);
   modport sink   (input valid, out_x, out_y, out_z, output ready);
endinterface

### rtl/wendland_kernel_bundle_warp.sv
// ----------------------------------------------------------------------------
// wendland_kernel_bundle_warp
// Warps 3-D points through bundled Wendland C2 or hat kernel levels (Q16.16).
// ----------------------------------------------------------------------------
// channel | dir | handshake        | payload
// req     | in  | valid / ready    | op, level, coef_index, coef_xyz, point_xyz
// rsp     | out | valid / ready    | out_x, out_y, out_z
// csr     | in  | csr_we           | csr_index, csr_data
//
// A load request is written in the idle state. An evaluate request runs, per
// composition, every configured level and every neighbour in its support cube;
// a hat neighbour skips the polynomial steps, and a neighbour with zero weight
// or an index past the memory skips the memory read.
// Each neighbour is dominated by the bit-serial square root and the divider;
// each composition ends with one division per axis.
// Reset is synchronous; coefficient memories are not cleared.
// req is held off while an evaluate runs; loads are accepted while a result
// waits on rsp.
module wendland_kernel_bundle_warp #(
   parameter int LEVELS      = 4,
   parameter int MAX_SUPPORT = 4,
   parameter int LEVEL_COEFS = 4096
) (
   input  logic                               clock,
   input  logic                               reset,
   wkbw_req_if.sink                           req,
   wkbw_rsp_if.source                         rsp,
   input  logic                               csr_we,
   input  logic [wkbw_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [wkbw_pkg::CSR_DATA_W-1:0]    csr_data
);

   localparam int DEPTH  = LEVELS * LEVEL_COEFS;
   localparam int AW     = $clog2(DEPTH);
   localparam int SW     = $clog2(MAX_SUPPORT + 1);
   localparam int CW     = $clog2(MAX_SUPPORT);
   localparam int NL_CAP = (LEVELS < wkbw_pkg::NDESC) ? LEVELS : wkbw_pkg::NDESC;

   // sequencer states
   localparam logic [4:0] ST_IDLE  = 5'd0;
   localparam logic [4:0] ST_COMP  = 5'd1;
   localparam logic [4:0] ST_LVL   = 5'd2;
   localparam logic [4:0] ST_UMUL  = 5'd3;
   localparam logic [4:0] ST_UWB   = 5'd4;
   localparam logic [4:0] ST_NB    = 5'd5;
   localparam logic [4:0] ST_SQMUL = 5'd6;
   localparam logic [4:0] ST_SQWB  = 5'd7;
   localparam logic [4:0] ST_SQWT  = 5'd8;
   localparam logic [4:0] ST_DVWT  = 5'd9;
   localparam logic [4:0] ST_P2MUL = 5'd10;
   localparam logic [4:0] ST_P2WB  = 5'd11;
   localparam logic [4:0] ST_P4MUL = 5'd12;
   localparam logic [4:0] ST_P4WB  = 5'd13;
   localparam logic [4:0] ST_DDMUL = 5'd14;
   localparam logic [4:0] ST_DDWB  = 5'd15;
   localparam logic [4:0] ST_L1MUL = 5'd16;
   localparam logic [4:0] ST_L1WB  = 5'd17;
   localparam logic [4:0] ST_L2MUL = 5'd18;
   localparam logic [4:0] ST_L2WB  = 5'd19;
   localparam logic [4:0] ST_L3MUL = 5'd20;
   localparam logic [4:0] ST_L3WB  = 5'd21;
   localparam logic [4:0] ST_RD    = 5'd22;
   localparam logic [4:0] ST_CMUL  = 5'd23;
   localparam logic [4:0] ST_CWB   = 5'd24;
   localparam logic [4:0] ST_NEXT  = 5'd25;
   localparam logic [4:0] ST_FDGO  = 5'd26;
   localparam logic [4:0] ST_FDWT  = 5'd27;
   localparam logic [4:0] ST_DONE  = 5'd28;

   localparam int ONE_Q16 = 65536;

   logic [4:0]                state_ff, state_in;
   logic [2:0]                nlev_ff, nlev_in;
   logic [4:0]                ncomp_ff, ncomp_in;
   wkbw_pkg::desc_type        desc_ff [wkbw_pkg::NDESC];
   wkbw_pkg::desc_type        desc_in [wkbw_pkg::NDESC];

   wkbw_pkg::q16_type         pt_ff [3], pt_in [3];
   logic signed [36:0]        u_ff [3], u_in [3];
   logic signed [63:0]        acc_ff [3], acc_in [3];
   logic [20:0]               a_ff [3], a_in [3];
   logic [7:0]                m_ff [3], m_in [3];
   logic [wkbw_pkg::SQ_W-1:0] sq_ff, sq_in;
   logic [22:0]               r_ff, r_in;
   logic [16:0]               pp_ff, pp_in;
   logic [16:0]               p2_ff, p2_in;
   logic [16:0]               p4_ff, p4_in;
   logic [19:0]               dd_ff, dd_in;
   logic [16:0]               t_ff, t_in;
   logic [15:0]               gg_ff, gg_in;
   logic [24:0]               lin_ff, lin_in;
   logic [1:0]                ax_ff, ax_in;
   logic [2:0]                lv_ff, lv_in;
   logic [CW-1:0]             jj_ff, jj_in, kk_ff, kk_in, ll_ff, ll_in;
   logic [SW-1:0]             sup_ff, sup_in;
   logic [4:0]                comp_ff, comp_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   wkbw_pkg::q16_type         out_ff [3], out_in [3];

   // shared units
   logic signed [wkbw_pkg::MUL_W-1:0]  mul_a, mul_b;
   logic signed [wkbw_pkg::PROD_W-1:0] prod;
   logic                               sq_start, sq_done;
   logic [wkbw_pkg::SQ_W-1:0]          sq_val;
   logic [wkbw_pkg::ROOT_W-1:0]        sq_root;
   logic                               dv_start, dv_done;
   logic [wkbw_pkg::DIV_W-1:0]         dv_num, dv_quo;
   logic [wkbw_pkg::DEN_W-1:0]         dv_den;

   // memory ports
   logic                      ram_we, ram_re;
   logic [AW-1:0]             ram_waddr, ram_raddr;
   logic [31:0]               rd_data [3];

   // current level and neighbour geometry
   wkbw_pkg::desc_type        cur_desc;
   logic [3:0]                dsup;
   logic [SW-1:0]             sup_cap;
   logic [2:0]                nl;
   logic [20:0]               nb_a [3];
   logic [7:0]                nb_m [3];

   // final division and saturation
   logic signed [47:0]        fd_acc;
   logic                      fd_neg;
   logic signed [47:0]        fd_disp;
   logic signed [48:0]        fd_sum;
   wkbw_pkg::q16_type         fd_sat;
   logic [24:0]               lin_sum;

   assign cur_desc = desc_ff[lv_ff[1:0]];
   assign dsup     = cur_desc.sup;
   assign sup_cap  = (32'(dsup) > MAX_SUPPORT) ? SW'(MAX_SUPPORT) : SW'(dsup);
   assign nl       = (32'(nlev_ff) > NL_CAP) ? 3'(NL_CAP) : nlev_ff;

   function automatic logic [7:0] clamp_cell(input logic signed [23:0] v,
                                             input logic [7:0] g);
      logic [7:0] c;
      if (v < 24'sd0) begin
         c = 8'd0;
      end else if (v > $signed({16'd0, g}) - 24'sd1) begin
         c = g - 8'd1;
      end else begin
         c = v[7:0];
      end
      return c;
   endfunction

   // neighbour cells, clamped distances per axis
   always_comb begin
      logic signed [4:0]  off;
      logic signed [23:0] s, idx, mraw, craw;
      logic [7:0]         g, c;
      logic [CW-1:0]      ctr;
      logic signed [37:0] dc;
      off = 5'sd1 - $signed({1'b0, 4'(sup_ff >> 1)});
      for (int ax = 0; ax < 3; ax++) begin
         ctr  = (ax == 0) ? ll_ff : ((ax == 1) ? kk_ff : jj_ff);
         s    = $signed(24'(ctr)) + 24'(off);
         idx  = 24'($signed(u_ff[ax][36:16]));
         g    = wkbw_pkg::desc_g(cur_desc, 2'(ax));
         mraw = idx - 24'sd1 + s;
         craw = idx + s;
         nb_m[ax] = clamp_cell(mraw, g);
         c    = clamp_cell(craw, g);
         dc   = {u_ff[ax][36], u_ff[ax]} - $signed({14'd0, c, 16'd0});
         if (dc > 38'sd1048576) begin
            dc = 38'sd1048576;
         end else if (dc < -38'sd1048576) begin
            dc = -38'sd1048576;
         end
         nb_a[ax] = 21'(dc < 0 ? -dc : dc);
      end
   end

   // final step: floor(acc / 2^16 / ncomp), add, saturate
   assign fd_acc  = acc_ff[ax_ff][63:16];
   assign fd_neg  = fd_acc[47];
   assign fd_disp = fd_neg ? ~$signed(dv_quo) : $signed(dv_quo);
   assign fd_sum  = 49'(pt_ff[ax_ff]) + 49'(fd_disp);
   always_comb begin
      if (fd_sum > 49'sd2147483647) begin
         fd_sat = 32'sh7fffffff;
      end else if (fd_sum < -49'sd2147483648) begin
         fd_sat = 32'sh80000000;
      end else begin
         fd_sat = fd_sum[31:0];
      end
   end

   assign lin_sum = 25'(t_ff) + prod[24:0];

   // sequencer
   always_comb begin
      state_in     = state_ff;
      nlev_in      = nlev_ff;
      ncomp_in     = ncomp_ff;
      desc_in      = desc_ff;
      pt_in        = pt_ff;
      u_in         = u_ff;
      acc_in       = acc_ff;
      a_in         = a_ff;
      m_in         = m_ff;
      sq_in        = sq_ff;
      r_in         = r_ff;
      pp_in        = pp_ff;
      p2_in        = p2_ff;
      p4_in        = p4_ff;
      dd_in        = dd_ff;
      t_in         = t_ff;
      gg_in        = gg_ff;
      lin_in       = lin_ff;
      ax_in        = ax_ff;
      lv_in        = lv_ff;
      jj_in        = jj_ff;
      kk_in        = kk_ff;
      ll_in        = ll_ff;
      sup_in       = sup_ff;
      comp_in      = comp_ff;
      out_in       = out_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      mul_a        = '0;
      mul_b        = '0;
      sq_start     = 1'b0;
      sq_val       = sq_ff + prod[wkbw_pkg::SQ_W-1:0];
      dv_start     = 1'b0;
      dv_num       = '0;
      dv_den       = '0;
      ram_we       = 1'b0;
      ram_re       = 1'b0;
      ram_waddr    = AW'(req.level) * AW'(LEVEL_COEFS) + AW'(req.coef_index);
      ram_raddr    = AW'(lv_ff) * AW'(LEVEL_COEFS) + AW'(lin_ff);

      // configuration writes
      if (csr_we) begin
         case (csr_index)
            wkbw_pkg::CSR_NUM_LEVELS: nlev_in    = csr_data[2:0];
            wkbw_pkg::CSR_NUM_COMPS:  ncomp_in   = csr_data[4:0];
            wkbw_pkg::CSR_DESC_0:     desc_in[0] = csr_data;
            wkbw_pkg::CSR_DESC_1:     desc_in[1] = csr_data;
            wkbw_pkg::CSR_DESC_2:     desc_in[2] = csr_data;
            wkbw_pkg::CSR_DESC_3:     desc_in[3] = csr_data;
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req.valid) begin
               if (req.op == wkbw_pkg::OP_LOAD) begin
                  ram_we = (32'(req.level) < LEVELS) && (32'(req.coef_index) < LEVEL_COEFS);
               end else begin
                  pt_in[0] = req.point_x;
                  pt_in[1] = req.point_y;
                  pt_in[2] = req.point_z;
                  comp_in  = '0;
                  state_in = (ncomp_ff == 5'd0) ? ST_DONE : ST_COMP;
               end
            end
         end
         ST_COMP: begin
            for (int i = 0; i < 3; i++) acc_in[i] = '0;
            lv_in    = '0;
            state_in = ST_LVL;
         end
         ST_LVL: begin
            // skip levels that contribute nothing; stop after the last
            if (lv_ff >= nl) begin
               ax_in    = '0;
               state_in = ST_FDGO;
            end else if (sup_cap == '0 || cur_desc.gx == 8'd0 || cur_desc.gy == 8'd0
                         || cur_desc.gz == 8'd0) begin
               lv_in = lv_ff + 3'd1;
            end else begin
               sup_in   = sup_cap;
               ax_in    = '0;
               jj_in    = '0;
               kk_in    = '0;
               ll_in    = '0;
               state_in = ST_UMUL;
            end
         end
         ST_UMUL: begin
            mul_a    = 33'(pt_ff[ax_ff]);
            mul_b    = $signed({21'd0, wkbw_pkg::desc_inv(cur_desc, ax_ff)});
            state_in = ST_UWB;
         end
         ST_UWB: begin
            u_in[ax_ff] = {prod[43], prod[43:8]} + 37'sd65536;
            if (ax_ff == 2'd2) begin
               state_in = ST_NB;
            end else begin
               ax_in    = ax_ff + 2'd1;
               state_in = ST_UMUL;
            end
         end
         ST_NB: begin
            a_in     = nb_a;
            m_in     = nb_m;
            sq_in    = '0;
            ax_in    = '0;
            state_in = ST_SQMUL;
         end
         ST_SQMUL: begin
            mul_a    = $signed({12'd0, a_ff[ax_ff]});
            mul_b    = $signed({12'd0, a_ff[ax_ff]});
            state_in = ST_SQWB;
         end
         ST_SQWB: begin
            sq_in = sq_val;
            if (ax_ff == 2'd2) begin
               sq_start = 1'b1;
               state_in = ST_SQWT;
            end else begin
               ax_in    = ax_ff + 2'd1;
               state_in = ST_SQMUL;
            end
         end
         ST_SQWT: begin
            // r = 2 * root / support
            dv_num = {25'd0, sq_root, 1'b0};
            dv_den = wkbw_pkg::DEN_W'(sup_ff);
            if (sq_done) begin
               dv_start = 1'b1;
               state_in = ST_DVWT;
            end
         end
         ST_DVWT: begin
            if (dv_done) begin
               r_in  = dv_quo[22:0];
               pp_in = (dv_quo < 48'(ONE_Q16)) ? 17'(48'(ONE_Q16) - dv_quo) : 17'd0;
               if (32'(sup_ff) > 2) begin
                  state_in = ST_P2MUL;
               end else begin
                  dd_in    = 20'(pp_in);
                  state_in = ST_L1MUL;
               end
            end
         end
         ST_P2MUL: begin
            mul_a    = $signed({16'd0, pp_ff});
            mul_b    = $signed({16'd0, pp_ff});
            state_in = ST_P2WB;
         end
         ST_P2WB: begin
            p2_in    = prod[32:16];
            state_in = ST_P4MUL;
         end
         ST_P4MUL: begin
            mul_a    = $signed({16'd0, p2_ff});
            mul_b    = $signed({16'd0, p2_ff});
            state_in = ST_P4WB;
         end
         ST_P4WB: begin
            p4_in    = prod[32:16];
            state_in = ST_DDMUL;
         end
         ST_DDMUL: begin
            mul_a    = $signed({16'd0, p4_ff});
            mul_b    = $signed(33'({r_ff, 2'b00}) + 33'(ONE_Q16));
            state_in = ST_DDWB;
         end
         ST_DDWB: begin
            dd_in    = prod[35:16];
            state_in = ST_L1MUL;
         end
         ST_L1MUL: begin
            // drop zero weights before touching memory
            mul_a = $signed({25'd0, cur_desc.gx});
            mul_b = $signed({25'd0, m_ff[1]});
            state_in = (dd_ff == 20'd0) ? ST_NEXT : ST_L1WB;
         end
         ST_L1WB: begin
            t_in     = 17'(m_ff[0]) + prod[16:0];
            state_in = ST_L2MUL;
         end
         ST_L2MUL: begin
            mul_a    = $signed({25'd0, cur_desc.gx});
            mul_b    = $signed({25'd0, cur_desc.gy});
            state_in = ST_L2WB;
         end
         ST_L2WB: begin
            gg_in    = prod[15:0];
            state_in = ST_L3MUL;
         end
         ST_L3MUL: begin
            mul_a    = $signed({17'd0, gg_ff});
            mul_b    = $signed({25'd0, m_ff[2]});
            state_in = ST_L3WB;
         end
         ST_L3WB: begin
            lin_in   = lin_sum;
            state_in = (32'(lin_sum) >= LEVEL_COEFS) ? ST_NEXT : ST_RD;
         end
         ST_RD: begin
            ram_re   = 1'b1;
            ax_in    = '0;
            state_in = ST_CMUL;
         end
         ST_CMUL: begin
            mul_a    = 33'($signed(rd_data[ax_ff]));
            mul_b    = $signed({13'd0, dd_ff});
            state_in = ST_CWB;
         end
         ST_CWB: begin
            acc_in[ax_ff] = acc_ff[ax_ff] + prod[63:0];
            if (ax_ff == 2'd2) begin
               state_in = ST_NEXT;
            end else begin
               ax_in    = ax_ff + 2'd1;
               state_in = ST_CMUL;
            end
         end
         ST_NEXT: begin
            // advance x fastest, then y, then z
            state_in = ST_NB;
            if (32'(ll_ff) != 32'(sup_ff) - 1) begin
               ll_in = ll_ff + 1'b1;
            end else begin
               ll_in = '0;
               if (32'(kk_ff) != 32'(sup_ff) - 1) begin
                  kk_in = kk_ff + 1'b1;
               end else begin
                  kk_in = '0;
                  if (32'(jj_ff) != 32'(sup_ff) - 1) begin
                     jj_in = jj_ff + 1'b1;
                  end else begin
                     jj_in    = '0;
                     lv_in    = lv_ff + 3'd1;
                     state_in = ST_LVL;
                  end
               end
            end
         end
         ST_FDGO: begin
            dv_num   = fd_neg ? ~fd_acc : fd_acc;
            dv_den   = ncomp_ff;
            dv_start = 1'b1;
            state_in = ST_FDWT;
         end
         ST_FDWT: begin
            if (dv_done) begin
               pt_in[ax_ff] = fd_sat;
               if (ax_ff == 2'd2) begin
                  comp_in  = comp_ff + 5'd1;
                  state_in = (comp_ff + 5'd1 == ncomp_ff) ? ST_DONE : ST_COMP;
               end else begin
                  ax_in    = ax_ff + 2'd1;
                  state_in = ST_FDGO;
               end
            end
         end
         ST_DONE: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp.ready) begin
               out_in       = pt_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         nlev_ff      <= 3'd1;
         ncomp_ff     <= 5'd1;
         for (int i = 0; i < wkbw_pkg::NDESC; i++) desc_ff[i] <= '0;
         rsp_valid_ff <= 1'b0;
         ax_ff        <= '0;
         lv_ff        <= '0;
         jj_ff        <= '0;
         kk_ff        <= '0;
         ll_ff        <= '0;
         comp_ff      <= '0;
         sup_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         nlev_ff      <= nlev_in;
         ncomp_ff     <= ncomp_in;
         desc_ff      <= desc_in;
         rsp_valid_ff <= rsp_valid_in;
         ax_ff        <= ax_in;
         lv_ff        <= lv_in;
         jj_ff        <= jj_in;
         kk_ff        <= kk_in;
         ll_ff        <= ll_in;
         comp_ff      <= comp_in;
         sup_ff       <= sup_in;
      end
      pt_ff  <= pt_in;
      u_ff   <= u_in;
      acc_ff <= acc_in;
      a_ff   <= a_in;
      m_ff   <= m_in;
      sq_ff  <= sq_in;
      r_ff   <= r_in;
      pp_ff  <= pp_in;
      p2_ff  <= p2_in;
      p4_ff  <= p4_in;
      dd_ff  <= dd_in;
      t_ff   <= t_in;
      gg_ff  <= gg_in;
      lin_ff <= lin_in;
      out_ff <= out_in;
   end

   assign req.ready = (state_ff == ST_IDLE);
   assign rsp.valid = rsp_valid_ff;
   assign rsp.out_x = out_ff[0];
   assign rsp.out_y = out_ff[1];
   assign rsp.out_z = out_ff[2];

   wkbw_mul u_mul (
      .clock (clock),
      .a     (mul_a),
      .b     (mul_b),
      .p     (prod)
   );

   wkbw_isqrt u_isqrt (
      .clock (clock),
      .reset (reset),
      .start (sq_start),
      .value (sq_val),
      .done  (sq_done),
      .root  (sq_root)
   );

   wkbw_div u_div (
      .clock (clock),
      .reset (reset),
      .start (dv_start),
      .num   (dv_num),
      .den   (dv_den),
      .done  (dv_done),
      .quo   (dv_quo)
   );

   wkbw_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_mem_x (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (req.coef_x),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (rd_data[0])
   );

   wkbw_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_mem_y (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (req.coef_y),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (rd_data[1])
   );

   wkbw_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_mem_z (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (req.coef_z),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (rd_data[2])
   );

endmodule

### rtl/wkbw_ram.sv
// ----------------------------------------------------------------------------
// wkbw_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module wkbw_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16384
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write, then registered read
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

### rtl/wkbw_mul.sv
// ----------------------------------------------------------------------------
// wkbw_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module wkbw_mul (
   input  logic                                 clock,
   input  logic signed [wkbw_pkg::MUL_W-1:0]    a,
   input  logic signed [wkbw_pkg::MUL_W-1:0]    b,
   output logic signed [wkbw_pkg::PROD_W-1:0]   p
);

   logic signed [wkbw_pkg::PROD_W-1:0] p_ff;

   // register the product for the next sequencer step
   always_ff @(posedge clock) begin
      p_ff <= a * b;
   end

   assign p = p_ff;

endmodule

### rtl/wkbw_isqrt.sv
// ----------------------------------------------------------------------------
// wkbw_isqrt
// Bit-serial integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module wkbw_isqrt (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [wkbw_pkg::SQ_W-1:0]        value,
   output logic                             done,
   output logic [wkbw_pkg::ROOT_W-1:0]      root
);

   localparam int RW = wkbw_pkg::SQ_W + 1;

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [RW-1:0] v_ff, v_in;
   logic [RW-1:0] res_ff, res_in;
   logic [RW-1:0] bit_ff, bit_in;
   logic [RW-1:0] trial;

   // one compare and subtract per step
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      v_in    = v_ff;
      res_in  = res_ff;
      bit_in  = bit_ff;
      trial   = res_ff + bit_ff;
      if (start) begin
         busy_in = 1'b1;
         v_in    = RW'(value);
         res_in  = '0;
         bit_in  = RW'(1) << (wkbw_pkg::SQ_W - 1);
      end else if (busy_ff) begin
         if (v_ff >= trial) begin
            v_in   = v_ff - trial;
            res_in = (res_ff >> 1) + bit_ff;
         end else begin
            res_in = res_ff >> 1;
         end
         bit_in = bit_ff >> 2;
         if (bit_ff == RW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      v_ff   <= v_in;
      res_ff <= res_in;
      bit_ff <= bit_in;
   end

   assign done = done_ff;
   assign root = res_ff[wkbw_pkg::ROOT_W-1:0];

endmodule

### rtl/wkbw_div.sv
// ----------------------------------------------------------------------------
// wkbw_div
// Restoring unsigned divider, one quotient bit per cycle, small divisor.
// ----------------------------------------------------------------------------
module wkbw_div (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [wkbw_pkg::DIV_W-1:0]     num,
   input  logic [wkbw_pkg::DEN_W-1:0]     den,
   output logic                           done,
   output logic [wkbw_pkg::DIV_W-1:0]     quo
);

   localparam int CNT_W = $clog2(wkbw_pkg::DIV_W);

   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [CNT_W-1:0]              cnt_ff, cnt_in;
   logic [wkbw_pkg::DIV_W-1:0]    q_ff, q_in;
   logic [wkbw_pkg::DEN_W-1:0]    rem_ff, rem_in;
   logic [wkbw_pkg::DEN_W-1:0]    den_ff, den_in;
   logic [wkbw_pkg::DEN_W:0]      trial;

   // shift one dividend bit into the remainder, subtract if it fits
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      q_in    = q_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      trial   = {rem_ff, q_ff[wkbw_pkg::DIV_W-1]};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         q_in    = num;
         rem_in  = '0;
         den_in  = den;
      end else if (busy_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in = wkbw_pkg::DEN_W'(trial - {1'b0, den_ff});
            q_in   = {q_ff[wkbw_pkg::DIV_W-2:0], 1'b1};
         end else begin
            rem_in = trial[wkbw_pkg::DEN_W-1:0];
            q_in   = {q_ff[wkbw_pkg::DIV_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(wkbw_pkg::DIV_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      q_ff   <= q_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done = done_ff;
   assign quo  = q_ff;

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Kernel bundle point warp testbench
// Loads the per-level coefficient memories, then runs directed and random
// load / evaluate requests over many register settings. A scoreboard predicts
// every warped point in Q16.16 and checks the responses in order, while both
// channels idle and stall at random.
// ----------------------------------------------------------------------------

typedef struct {
   logic signed [31:0] x;
   logic signed [31:0] y;
   logic signed [31:0] z;
} point_type;

class warp_scoreboard;
   int                  mem_x[4][4096];
   int                  mem_y[4][4096];
   int                  mem_z[4][4096];
   logic [2:0]          num_levels;
   logic [4:0]          num_comps;
   wkbw_pkg::desc_type  descs[wkbw_pkg::NDESC];
   longint              step_sum[3];
   point_type           expected_points[$];
   int                  mismatches;
   int                  loads_seen;
   int                  evals_seen;
   int                  points_checked;

   function new();
      num_levels = 3'd1;
      num_comps  = 5'd1;
      foreach (descs[i]) descs[i] = '0;
      mismatches = 0;
      loads_seen = 0;
      evals_seen = 0;
      points_checked = 0;
   endfunction

   function void write_reg(logic [wkbw_pkg::CSR_IDX_W-1:0] idx, logic [63:0] data);
      case (idx)
         wkbw_pkg::CSR_NUM_LEVELS: num_levels = data[2:0];
         wkbw_pkg::CSR_NUM_COMPS:  num_comps  = data[4:0];
         wkbw_pkg::CSR_DESC_0:     descs[0]   = data;
         wkbw_pkg::CSR_DESC_1:     descs[1]   = data;
         wkbw_pkg::CSR_DESC_2:     descs[2]   = data;
         wkbw_pkg::CSR_DESC_3:     descs[3]   = data;
         default: ;
      endcase
   endfunction

   function longint unsigned int_sqrt(longint unsigned v);
      longint unsigned res;
      longint unsigned b;
      res = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= res + b) begin
            v = v - (res + b);
            res = (res >> 1) + b;
         end else begin
            res = res >> 1;
         end
         b = b >> 2;
      end
      return res;
   endfunction

   function longint clamp(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   // add one level's weighted coefficients (Q32.32) into step_sum
   function void add_level(int lv, longint pt[3]);
      wkbw_pkg::desc_type d;
      longint sup, off, g[3], u[3], idx[3], inv[3], s[3], m[3], c[3], dc;
      longint unsigned sq, a, r1, r, pp, p2, p4, wt, lin;
      d = descs[lv];
      sup = d.sup;
      if (sup > 4) sup = 4;
      if (sup == 0) return;
      g[0] = d.gx;  g[1] = d.gy;  g[2] = d.gz;
      inv[0] = d.inv_x;  inv[1] = d.inv_y;  inv[2] = d.inv_z;
      for (int ax = 0; ax < 3; ax++) begin
         if (g[ax] == 0) return;
         u[ax] = ((pt[ax] * inv[ax]) >>> 8) + 65536;
         idx[ax] = u[ax] >>> 16;
      end
      off = 1 - sup / 2;
      for (longint j = 0; j < sup; j++)
         for (longint k = 0; k < sup; k++)
            for (longint l = 0; l < sup; l++) begin
               s[0] = l + off;  s[1] = k + off;  s[2] = j + off;
               sq = 0;
               for (int ax = 0; ax < 3; ax++) begin
                  m[ax] = clamp(idx[ax] - 1 + s[ax], 0, g[ax] - 1);
                  c[ax] = clamp(idx[ax] + s[ax], 0, g[ax] - 1);
                  dc = clamp(u[ax] - c[ax] * 65536, -(64'sd1 << 20), 64'sd1 << 20);
                  a = dc < 0 ? -dc : dc;
                  sq += a * a;
               end
               r1 = int_sqrt(sq);
               r = (r1 * 2) / sup;
               pp = r < 65536 ? 65536 - r : 0;
               if (sup > 2) begin
                  p2 = (pp * pp) >> 16;
                  p4 = (p2 * p2) >> 16;
                  wt = (p4 * (4 * r + 65536)) >> 16;
               end else begin
                  wt = pp;
               end
               if (wt == 0) continue;
               lin = m[0] + g[0] * m[1] + g[0] * g[1] * m[2];
               if (lin >= 4096) continue;
               step_sum[0] += longint'(wt) * longint'(mem_x[lv][lin]);
               step_sum[1] += longint'(wt) * longint'(mem_y[lv][lin]);
               step_sum[2] += longint'(wt) * longint'(mem_z[lv][lin]);
            end
   endfunction

   function point_type warp_point(wkbw_pkg::q16_type px, wkbw_pkg::q16_type py,
                                  wkbw_pkg::q16_type pz);
      longint pt[3];
      longint den, q;
      int nl;
      point_type res;
      pt[0] = px;  pt[1] = py;  pt[2] = pz;
      nl = num_levels > 4 ? 4 : num_levels;
      den = longint'(num_comps) * 65536;
      for (int st = 0; st < num_comps; st++) begin
         step_sum = '{0, 0, 0};
         for (int lv = 0; lv < nl; lv++) add_level(lv, pt);
         for (int ax = 0; ax < 3; ax++) begin
            q = step_sum[ax] / den;
            if ((step_sum[ax] % den) != 0 && step_sum[ax] < 0) q--;
            pt[ax] = clamp(pt[ax] + q, -64'sd2147483648, 64'sd2147483647);
         end
      end
      res.x = 32'(pt[0]);  res.y = 32'(pt[1]);  res.z = 32'(pt[2]);
      return res;
   endfunction

   function void note_request(logic op, logic [1:0] lv, logic [11:0] ci,
                              wkbw_pkg::q16_type cx, wkbw_pkg::q16_type cy,
                              wkbw_pkg::q16_type cz, wkbw_pkg::q16_type px,
                              wkbw_pkg::q16_type py, wkbw_pkg::q16_type pz);
      if (op == wkbw_pkg::OP_LOAD) begin
         mem_x[lv][ci] = cx;
         mem_y[lv][ci] = cy;
         mem_z[lv][ci] = cz;
         loads_seen++;
      end else begin
         expected_points.push_back(warp_point(px, py, pz));
         evals_seen++;
      end
   endfunction

   function void check_result(wkbw_pkg::q16_type ox, wkbw_pkg::q16_type oy,
                              wkbw_pkg::q16_type oz);
      point_type e;
      if (expected_points.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("unexpected response: %0d %0d %0d", ox, oy, oz);
         return;
      end
      e = expected_points.pop_front();
      points_checked++;
      if (e.x !== ox || e.y !== oy || e.z !== oz) begin
         mismatches++;
         if (mismatches <= 10)
            $display("point mismatch: expected %0d %0d %0d, got %0d %0d %0d",
                     e.x, e.y, e.z, ox, oy, oz);
      end
   endfunction
endclass

module tb;
   localparam int WATCHDOG_LIMIT = 300000;
   localparam int RANDOM_ITEMS   = 880;

   logic clock;
   logic reset;
   logic csr_we;
   logic [wkbw_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [wkbw_pkg::CSR_DATA_W-1:0] csr_data;
   logic quiet;
   int   hold_cnt;
   int   idle_cycles;
   int   random_items;

   wkbw_req_if req_ch();
   wkbw_rsp_if rsp_ch();
   warp_scoreboard sb;

   wendland_kernel_bundle_warp u_dut (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .rsp       (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   // stall the response side in random stretches, none while quiet
   always @(posedge clock) begin
      if (quiet) begin
         rsp_ch.ready <= 1'b1;
      end else if (hold_cnt > 0) begin
         hold_cnt <= hold_cnt - 1;
      end else begin
         rsp_ch.ready <= ($urandom_range(0, 3) != 0);
         hold_cnt <= ($urandom_range(0, 19) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(0, 2);
      end
   end

   // note accepted requests, check accepted responses, watch for a hang
   always @(posedge clock) begin
      if (!reset) begin
         if (req_ch.valid && req_ch.ready)
            sb.note_request(req_ch.op, req_ch.level, req_ch.coef_index,
                            req_ch.coef_x, req_ch.coef_y, req_ch.coef_z,
                            req_ch.point_x, req_ch.point_y, req_ch.point_z);
         if (rsp_ch.valid && rsp_ch.ready)
            sb.check_result(rsp_ch.out_x, rsp_ch.out_y, rsp_ch.out_z);
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired, %0d points outstanding",
                     sb.expected_points.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   function automatic logic [63:0] make_desc(int sup, int gx, int gy, int gz,
                                             int ix, int iy, int iz);
      wkbw_pkg::desc_type d;
      d.sup = 4'(sup);  d.gx = 8'(gx);  d.gy = 8'(gy);  d.gz = 8'(gz);
      d.inv_x = 12'(ix);  d.inv_y = 12'(iy);  d.inv_z = 12'(iz);
      return d;
   endfunction

   task automatic write_csr(logic [wkbw_pkg::CSR_IDX_W-1:0] idx, logic [63:0] data);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      sb.write_reg(idx, data);
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic write_all(int nl, int nc, logic [63:0] d0, logic [63:0] d1,
                            logic [63:0] d2, logic [63:0] d3);
      write_csr(wkbw_pkg::CSR_NUM_LEVELS, 64'(nl));
      write_csr(wkbw_pkg::CSR_NUM_COMPS, 64'(nc));
      write_csr(wkbw_pkg::CSR_DESC_0, d0);
      write_csr(wkbw_pkg::CSR_DESC_1, d1);
      write_csr(wkbw_pkg::CSR_DESC_2, d2);
      write_csr(wkbw_pkg::CSR_DESC_3, d3);
   endtask

   // hold one request until accepted, then maybe pause
   task automatic send_req(logic op, logic [1:0] lv, logic [11:0] ci,
                           wkbw_pkg::q16_type cx, wkbw_pkg::q16_type cy,
                           wkbw_pkg::q16_type cz, wkbw_pkg::q16_type px,
                           wkbw_pkg::q16_type py, wkbw_pkg::q16_type pz);
      int gap;
      req_ch.valid <= 1'b1;
      req_ch.op <= op;
      req_ch.level <= lv;
      req_ch.coef_index <= ci;
      req_ch.coef_x <= cx;  req_ch.coef_y <= cy;  req_ch.coef_z <= cz;
      req_ch.point_x <= px;  req_ch.point_y <= py;  req_ch.point_z <= pz;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      if (quiet) gap = 0;
      else if ($urandom_range(0, 19) == 0) gap = $urandom_range(10, 40);
      else gap = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic load(int lv, int ci, wkbw_pkg::q16_type cx, wkbw_pkg::q16_type cy,
                       wkbw_pkg::q16_type cz);
      send_req(wkbw_pkg::OP_LOAD, 2'(lv), 12'(ci), cx, cy, cz,
               $urandom, $urandom, $urandom);
   endtask

   task automatic eval(wkbw_pkg::q16_type px, wkbw_pkg::q16_type py,
                       wkbw_pkg::q16_type pz);
      send_req(wkbw_pkg::OP_EVAL, 2'($urandom), 12'($urandom), $urandom, $urandom,
               $urandom, px, py, pz);
   endtask

   // drop valid and wait out every outstanding point plus a settle margin
   task automatic drain();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (sb.expected_points.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
   endtask

   function automatic wkbw_pkg::q16_type small_coord();
      return $urandom_range(0, 1 << 20) - (1 << 19);
   endfunction

   function automatic wkbw_pkg::q16_type rand_coef();
      return ($urandom_range(0, 3) == 0) ? wkbw_pkg::q16_type'($urandom)
             : wkbw_pkg::q16_type'($urandom_range(0, 1 << 18) - (1 << 17));
   endfunction

   function automatic logic [63:0] rand_desc(bit heavy);
      int sup, gx, gy, gz;
      sup = heavy ? $urandom_range(3, 15) : $urandom_range(1, 2);
      if ($urandom_range(0, 9) == 0) sup = 0;
      gx = $urandom_range(1, 4);
      gy = $urandom_range(1, 4);
      gz = $urandom_range(1, 4);
      if ($urandom_range(0, 14) == 0) gy = 0;
      return make_desc(sup, gx, gy, gz, $urandom_range(0, 4095),
                       $urandom_range(0, 4095), $urandom_range(0, 4095));
   endfunction

   initial begin
      bit heavy;
      int nl, nc, n_items;
      sb = new();
      quiet = 1'b0;
      hold_cnt = 0;
      idle_cycles = 0;
      random_items = 0;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = '0;
      csr_data = '0;
      req_ch.valid = 1'b0;
      req_ch.op = wkbw_pkg::OP_LOAD;
      req_ch.level = '0;
      req_ch.coef_index = '0;
      req_ch.coef_x = '0;  req_ch.coef_y = '0;  req_ch.coef_z = '0;
      req_ch.point_x = '0;  req_ch.point_y = '0;  req_ch.point_z = '0;
      rsp_ch.ready = 1'b1;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // fill every cell that small grids can reach, plus a few wide-grid cells
      for (int lv = 0; lv < 4; lv++)
         for (int ci = 0; ci < 64; ci++)
            load(lv, ci, rand_coef(), rand_coef(), rand_coef());
      for (int i = 0; i < 3; i++) begin
         load(0, 64 + i, rand_coef(), rand_coef(), rand_coef());
         load(0, 128 + i, rand_coef(), rand_coef(), rand_coef());
      end

      // reset settings: level 0 has zero support, points pass unchanged
      load(3, 4095, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff);
      eval(32'sh7fffffff, 32'sh80000000, 32'sh7fffffff);
      eval(32'sh80000000, 32'sh7fffffff, 32'sh0);
      drain();

      // hat kernel on a 4x4x4 grid at unit spacing
      write_all(1, 1, make_desc(2, 4, 4, 4, 256, 256, 256), 0, 0, 0);
      eval(0, 0, 0);
      eval(32'sh00018000, 32'sh00024000, 32'sh00008000);
      drain();

      // all four Wendland levels at once, extreme scales clamp the distance
      write_all(4, 1, make_desc(4, 4, 4, 4, 256, 256, 256),
                make_desc(3, 4, 4, 4, 4095, 128, 512),
                make_desc(4, 4, 4, 4, 100, 300, 700),
                make_desc(15, 4, 4, 4, 256, 0, 256));
      eval(32'sh00012345, 32'sh0002abcd, 32'shffff8000);
      drain();

      // sixteen compositions, then none, then zero and capped levels
      write_all(1, 16, make_desc(1, 4, 4, 4, 256, 256, 256), 0, 0, 0);
      eval(32'sh00010000, 32'sh00020000, 32'sh80000000);
      drain();
      write_csr(wkbw_pkg::CSR_NUM_COMPS, 0);
      eval(32'sh00010000, 32'sh00020000, 32'sh00030000);
      drain();
      write_all(0, 1, make_desc(1, 4, 4, 4, 256, 256, 256), 0, 0, 0);
      eval(32'sh00010000, 32'sh00010000, 32'sh00010000);
      drain();
      write_all(7, 2, make_desc(2, 4, 4, 4, 256, 256, 256),
                make_desc(1, 0, 4, 4, 256, 256, 256),
                make_desc(2, 4, 4, 4, 0, 0, 0),
                make_desc(2, 255, 1, 1, 0, 256, 256));
      eval(32'sh00014000, 32'sh7fffffff, 32'sh00028000);
      drain();

      // widest single axes, and a grid whose upper cells lie past the memory
      write_all(3, 1, make_desc(4, 1, 255, 1, 256, 0, 256),
                make_desc(4, 1, 1, 255, 256, 256, 0),
                make_desc(4, 64, 64, 2, 0, 0, 0), 0);
      eval(32'sh00008000, 32'sh00004000, 32'sh0000c000);
      drain();

      // random phases: mostly light kernels, now and then a heavy one
      while (random_items < RANDOM_ITEMS) begin
         heavy = ($urandom_range(0, 6) == 0);
         quiet = ($urandom_range(0, 3) == 0);
         if (heavy) begin
            nl = $urandom_range(1, 2);
            nc = 1;
         end else begin
            nl = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 7) : $urandom_range(1, 4);
            nc = ($urandom_range(0, 11) == 0) ? $urandom_range(0, 16) : $urandom_range(1, 2);
            if (nc > 4) nl = 1;
         end
         write_all(nl, nc, rand_desc(heavy), rand_desc(heavy), rand_desc(heavy),
                   rand_desc(heavy));
         n_items = heavy ? 6 : 24;
         for (int i = 0; i < n_items; i++) begin
            if ($urandom_range(0, 1) == 0) begin
               load($urandom_range(0, 3),
                    ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095)
                                                : $urandom_range(0, 63),
                    rand_coef(), rand_coef(), rand_coef());
            end else if ($urandom_range(0, 4) == 0) begin
               eval($urandom, $urandom, $urandom);
            end else begin
               eval(small_coord(), small_coord(), small_coord());
            end
            random_items++;
         end
         drain();
      end
      quiet = 1'b0;

      $display("ran %0d loads and %0d evaluates, %0d warped points checked",
               sb.loads_seen, sb.evals_seen, sb.points_checked);
      $display("settings spanned zero to four levels, up to sixteen compositions,",
               " hat and Wendland kernels");
      if (sb.mismatches == 0 && sb.expected_points.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("%0d mismatches, %0d points missing", sb.mismatches,
                  sb.expected_points.size());
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end
endmodule

### wendland_kernel_bundle_warp.f
rtl/wkbw_pkg.sv
rtl/wkbw_if.sv
rtl/wkbw_ram.sv
rtl/wkbw_mul.sv
rtl/wkbw_isqrt.sv
rtl/wkbw_div.sv
rtl/wendland_kernel_bundle_warp.sv
tb/tb.sv
